>>> src/nccm_pkg.sv
// Package: shared types and constants of the completion commit engine.
`default_nettype none
package nccm_pkg;
    localparam int RING_DEPTH_DEF = 256;
    localparam int NUM_QUEUES_DEF = 16;

    localparam logic [2:0] OP_ENQ   = 3'd0;
    localparam logic [2:0] OP_SCAN  = 3'd1;
    localparam logic [2:0] OP_DBELL = 3'd2;
    localparam logic [2:0] OP_SQH   = 3'd3;
    localparam logic [2:0] OP_IRQ   = 3'd4;

    localparam logic [1:0] K_DONE = 2'd0;
    localparam logic [1:0] K_CQE  = 2'd1;
    localparam logic [1:0] K_IRQ  = 2'd2;
    localparam logic [1:0] K_REJ  = 2'd3;

    localparam logic [2:0] REG_CQ_SIZE   = 3'd0;
    localparam logic [2:0] REG_RING_SIZE = 3'd1;
    localparam logic [2:0] REG_MAX_SCAN  = 3'd2;
    localparam logic [2:0] REG_IRQ_MASK  = 3'd3;
    localparam logic [2:0] REG_QID_FIRST = 3'd4;
    localparam logic [2:0] REG_QID_LAST  = 3'd5;
    localparam logic [2:0] REG_QID_STEP  = 3'd6;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] time_value;
        logic        internal_flag;
        logic [3:0]  cq_index;
        logic [3:0]  sq_index;
        logic [15:0] cmd_ident;
        logic [15:0] head_value;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  out_cq;
        logic [15:0] cq_slot;
        logic [15:0] out_sq_head;
        logic [3:0]  out_sq;
        logic [15:0] out_cmd;
        logic        phase_bit;
        logic [8:0]  retired;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_WAIT, ST_EVAL, ST_EMIT, ST_IRQ, ST_DONE
    } t_state;
endpackage
`default_nettype wire

>>> src/nccm_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module nccm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> src/nccm_front.sv
// Front end: two-entry queue of items.
`default_nettype none
module nccm_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  nccm_pkg::t_item i_item,
    output logic            o_valid,
    input  wire             i_ready,
    output nccm_pkg::t_item o_item
);
    nccm_pkg::t_item r_q [2];
    logic [1:0] r_cnt;
    logic       r_rp, r_wp;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end
endmodule
`default_nettype wire

>>> src/nccm_back.sv
// Back end: ring walk, queue pointer state and result sequencing.
`default_nettype none
module nccm_back #(
    parameter int RING_DEPTH = nccm_pkg::RING_DEPTH_DEF,
    parameter int NUM_QUEUES = nccm_pkg::NUM_QUEUES_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  nccm_pkg::t_item   i_item,
    output logic              o_valid,
    input  wire               i_ready,
    output nccm_pkg::t_result o_res,
    input  wire  [16:0]       i_cq_size,
    input  wire  [8:0]        i_ring_size,
    input  wire  [5:0]        i_max_scan,
    input  wire  [15:0]       i_irq_mask,
    input  wire  [3:0]        i_qid_first,
    input  wire  [3:0]        i_qid_last,
    input  wire  [3:0]        i_qid_stride
);
    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    nccm_pkg::t_state r_st, n_st;
    nccm_pkg::t_item  r_it;
    logic [AW-1:0] r_head, r_tail, r_j;
    logic [CW-1:0] r_count, r_walked, r_total;
    logic [5:0]    r_counted;
    logic          r_at_head;
    logic [8:0]    r_retired;
    logic [4:0]    r_q;
    logic [15:0] r_cq_tail [NUM_QUEUES];
    logic [15:0] r_cq_head [NUM_QUEUES];
    logic [15:0] r_sq_head [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_phase, r_irq;
    nccm_pkg::t_result r_res;
    logic              r_ovalid;

    logic [63:0]   rd_time;
    logic [24:0]   rd_info;
    logic          rd_done;
    logic          ram_we, done_we, done_wdata;
    logic [AW-1:0] done_waddr;

    // effective sizes
    logic [CW-1:0] eff_ring;
    logic [16:0]   eff_cq;
    logic [5:0]    limit;
    logic [3:0]    step;
    always_comb begin
        if (i_ring_size < 9'd2) eff_ring = CW'(2);
        else if ({23'd0, i_ring_size} > RING_DEPTH) eff_ring = CW'(RING_DEPTH);
        else eff_ring = CW'(i_ring_size);
        if (i_cq_size < 17'd2) eff_cq = 17'd2;
        else if (i_cq_size > 17'd65536) eff_cq = 17'd65536;
        else eff_cq = i_cq_size;
        limit = (i_max_scan == 6'd0) ? 6'd1 : i_max_scan;
        step  = (i_qid_stride == 4'd0) ? 4'd1 : i_qid_stride;
    end

    function automatic logic [AW-1:0] rnext(input logic [AW-1:0] i, input logic [CW-1:0] n);
        logic [CW:0] s;
        s = {1'b0, CW'(i)} + 1'b1;
        return (s >= {1'b0, n}) ? '0 : AW'(s);
    endfunction

    nccm_ram #(.WIDTH(64), .DEPTH(RING_DEPTH)) u_time (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_tail), .i_wdata(i_item.time_value),
        .i_raddr(r_j), .o_rdata(rd_time));
    nccm_ram #(.WIDTH(25), .DEPTH(RING_DEPTH)) u_info (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_tail),
        .i_wdata({i_item.cmd_ident, i_item.sq_index, i_item.cq_index, i_item.internal_flag}),
        .i_raddr(r_j), .o_rdata(rd_info));
    nccm_ram #(.WIDTH(1), .DEPTH(RING_DEPTH)) u_done (
        .i_clk(i_clk), .i_we(done_we), .i_waddr(done_waddr), .i_wdata(done_wdata),
        .i_raddr(r_j), .o_rdata(rd_done));

    // entry decode for the current walk slot
    logic [3:0]    e_cq, e_sq;
    logic [QW-1:0] e_cqi, e_sqi;
    logic          e_cq_ok, e_sq_ok, e_due, e_pend, e_post, e_done;
    logic [16:0]   nxt17;
    logic [15:0]   e_next;
    logic          e_full;
    always_comb begin
        e_cq    = rd_info[4:1];
        e_sq    = rd_info[8:5];
        e_cq_ok = {28'd0, e_cq} < NUM_QUEUES;
        e_sq_ok = {28'd0, e_sq} < NUM_QUEUES;
        e_cqi   = QW'(e_cq);
        e_sqi   = QW'(e_sq);
        e_due   = rd_time <= r_it.time_value;
        e_pend  = !rd_done;
        nxt17   = {1'b0, r_cq_tail[e_cqi]} + 17'd1;
        e_next  = (nxt17 >= eff_cq) ? 16'd0 : nxt17[15:0];
        e_full  = e_next == r_cq_head[e_cqi];
        e_post  = e_pend && e_due && !rd_info[0] && e_cq_ok && !e_full;
        // an internal entry, or one for a queue beyond the table, settles without posting
        e_done  = !e_pend || (e_due && (rd_info[0] || !e_cq_ok || !e_full));
    end

    logic          busy_in, out_free, enq_full, eval_st, irq_fin, q_hit, counted_hit;
    logic [QW-1:0] qi;
    logic [CW:0]   walked_n;
    assign out_free    = !r_ovalid || i_ready;
    assign o_valid     = r_ovalid;
    assign o_res       = r_res;
    assign o_ready     = (r_st == nccm_pkg::ST_IDLE) && out_free;
    assign busy_in     = i_valid && o_ready;
    assign enq_full    = r_count >= eff_ring;
    assign eval_st     = r_st == nccm_pkg::ST_EVAL;
    assign ram_we      = busy_in && i_item.opcode == nccm_pkg::OP_ENQ && !enq_full;
    // write back the settled flag during the walk; clear it for a newly queued slot
    assign done_we     = ram_we || eval_st;
    assign done_waddr  = eval_st ? r_j : r_tail;
    assign done_wdata  = eval_st && e_done;
    assign qi          = QW'(r_q[3:0]);
    assign q_hit       = ({27'd0, r_q} < NUM_QUEUES) && i_irq_mask[r_q[3:0]] && r_irq[qi];
    assign irq_fin     = ({1'b0, r_q} > {2'b0, i_qid_last}) || r_q[4];
    assign counted_hit = e_pend && ((r_counted + 6'd1) >= limit);
    assign walked_n    = {1'b0, r_walked} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= nccm_pkg::ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            nccm_pkg::ST_IDLE: begin
                if (busy_in) begin
                    if (i_item.opcode == nccm_pkg::OP_SCAN)
                        n_st = (r_count == '0) ? nccm_pkg::ST_DONE : nccm_pkg::ST_RD;
                    else if (i_item.opcode == nccm_pkg::OP_IRQ)
                        n_st = nccm_pkg::ST_IRQ;
                end
            end
            nccm_pkg::ST_RD:   n_st = nccm_pkg::ST_WAIT;
            nccm_pkg::ST_WAIT: n_st = nccm_pkg::ST_EVAL;
            nccm_pkg::ST_EVAL: n_st = nccm_pkg::ST_EMIT;
            nccm_pkg::ST_EMIT: begin
                if (out_free) n_st = (r_total == '0) ? nccm_pkg::ST_DONE : nccm_pkg::ST_RD;
            end
            nccm_pkg::ST_IRQ:  if (out_free && irq_fin) n_st = nccm_pkg::ST_DONE;
            nccm_pkg::ST_DONE: if (out_free) n_st = nccm_pkg::ST_IDLE;
            default:           n_st = nccm_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        nccm_pkg::t_result v_res;
        logic              v_ovalid;
        if (!i_rst_n) begin
            r_head <= '0; r_tail <= '0; r_count <= '0;
            r_phase <= '1; r_irq <= '0; r_ovalid <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_cq_tail[q] <= '0; r_cq_head[q] <= '0; r_sq_head[q] <= '0;
            end
        end else begin
            v_res    = r_res;
            v_ovalid = r_ovalid && !i_ready;
            unique case (r_st)
                nccm_pkg::ST_IDLE: begin
                    if (busy_in) begin
                        r_it      <= i_item;
                        r_j       <= r_head;
                        r_walked  <= '0;
                        r_counted <= '0;
                        r_at_head <= 1'b1;
                        r_retired <= '0;
                        r_total   <= r_count;
                        r_q       <= {1'b0, i_qid_first};
                        v_res      = '0;
                        v_res.last = 1'b1;
                        // scan and irq poll answer later from their own states
                        v_ovalid   = (i_item.opcode != nccm_pkg::OP_SCAN)
                                     && (i_item.opcode != nccm_pkg::OP_IRQ);
                        unique case (i_item.opcode)
                            nccm_pkg::OP_ENQ: begin
                                if (enq_full) begin
                                    v_res.kind = nccm_pkg::K_REJ;
                                end else begin
                                    r_tail  <= rnext(r_tail, eff_ring);
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            nccm_pkg::OP_DBELL:
                                if ({28'd0, i_item.cq_index} < NUM_QUEUES)
                                    r_cq_head[QW'(i_item.cq_index)] <= i_item.head_value;
                            nccm_pkg::OP_SQH:
                                if ({28'd0, i_item.sq_index} < NUM_QUEUES)
                                    r_sq_head[QW'(i_item.sq_index)] <= i_item.head_value;
                            default: ;
                        endcase
                    end
                end
                nccm_pkg::ST_EVAL: begin
                    if (e_post) begin
                        v_res             = '0;
                        v_res.kind        = nccm_pkg::K_CQE;
                        v_res.out_cq      = e_cq;
                        v_res.cq_slot     = r_cq_tail[e_cqi];
                        v_res.out_sq_head = e_sq_ok ? r_sq_head[e_sqi] : 16'd0;
                        v_res.out_sq      = e_sq;
                        v_res.out_cmd     = rd_info[24:9];
                        v_res.phase_bit   = r_phase[e_cqi];
                        v_ovalid          = 1'b1;
                        if (e_next == 16'd0) r_phase[e_cqi] <= ~r_phase[e_cqi];
                        r_cq_tail[e_cqi] <= e_next;
                        r_irq[e_cqi]     <= 1'b1;
                    end
                    if (e_pend) r_counted <= r_counted + 6'd1;
                    if (e_done && r_at_head) begin
                        r_head    <= rnext(r_head, eff_ring);
                        r_count   <= r_count - 1'b1;
                        r_retired <= r_retired + 9'd1;
                    end else begin
                        r_at_head <= 1'b0;
                    end
                    r_j      <= rnext(r_j, eff_ring);
                    r_walked <= CW'(walked_n);
                    if (counted_hit || walked_n >= {1'b0, r_total}) r_total <= '0;
                end
                nccm_pkg::ST_IRQ: begin
                    if (out_free && !irq_fin) begin
                        if (q_hit) begin
                            r_irq[qi]    <= 1'b0;
                            v_res        = '0;
                            v_res.kind   = nccm_pkg::K_IRQ;
                            v_res.out_cq = r_q[3:0];
                            v_ovalid     = 1'b1;
                        end
                        r_q <= r_q + {1'b0, step};
                    end
                end
                nccm_pkg::ST_DONE: begin
                    if (out_free) begin
                        v_res         = '0;
                        v_res.kind    = nccm_pkg::K_DONE;
                        v_res.retired = r_retired;
                        v_res.last    = 1'b1;
                        v_ovalid      = 1'b1;
                    end
                end
                default: ;
            endcase
            r_res    <= v_res;
            r_ovalid <= v_ovalid;
        end
    end
endmodule
`default_nettype wire

>>> src/nvme_completion_commit_engine_core.sv
// Top level of the completion commit engine: register port, front queue and back end.
// Keeps a ring of pending command descriptors and posts completion entries with the phase
// tag when a scan finds them due. Items pass a two-entry input queue and the back end takes
// one at a time; an enqueue, doorbell, submission-head or unknown op is answered from idle.
// A scan walks each ring entry through read, wait, compare and post, and hand-off; max_scan
// caps only the entries still pending, so a scan may walk the whole occupancy, up to a
// full 256-entry ring. An irq poll visits queue ids from qid_first to qid_last by the
// stride. A result not yet taken holds the back end, and the input queue then fills and
// drops o_ready.
`default_nettype none
module nvme_completion_commit_engine_core #(
    parameter int RING_DEPTH = nccm_pkg::RING_DEPTH_DEF,
    parameter int NUM_QUEUES = nccm_pkg::NUM_QUEUES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_opcode,
    input  wire  [63:0] i_time_value,
    input  wire         i_internal_flag,
    input  wire  [3:0]  i_cq_index,
    input  wire  [3:0]  i_sq_index,
    input  wire  [15:0] i_cmd_ident,
    input  wire  [15:0] i_head_value,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_out_cq,
    output logic [15:0] o_cq_slot,
    output logic [15:0] o_out_sq_head,
    output logic [3:0]  o_out_sq,
    output logic [15:0] o_out_cmd,
    output logic        o_phase_bit,
    output logic [8:0]  o_retired,
    output logic        o_last
);
    logic [16:0] r_cq_size;
    logic [8:0]  r_ring_size;
    logic [5:0]  r_max_scan;
    logic [15:0] r_irq_mask;
    logic [3:0]  r_qid_first, r_qid_last, r_qid_stride;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cq_size <= 17'd256; r_ring_size <= 9'd256; r_max_scan <= 6'd63;
            r_irq_mask <= '0; r_qid_first <= '0; r_qid_last <= 4'd15; r_qid_stride <= 4'd1;
        end else if (wr) begin
            unique case (paddr[4:2])
                nccm_pkg::REG_CQ_SIZE:   r_cq_size    <= pwdata[16:0];
                nccm_pkg::REG_RING_SIZE: r_ring_size  <= pwdata[8:0];
                nccm_pkg::REG_MAX_SCAN:  r_max_scan   <= pwdata[5:0];
                nccm_pkg::REG_IRQ_MASK:  r_irq_mask   <= pwdata[15:0];
                nccm_pkg::REG_QID_FIRST: r_qid_first  <= pwdata[3:0];
                nccm_pkg::REG_QID_LAST:  r_qid_last   <= pwdata[3:0];
                nccm_pkg::REG_QID_STEP:  r_qid_stride <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            nccm_pkg::REG_CQ_SIZE:   prdata = {15'd0, r_cq_size};
            nccm_pkg::REG_RING_SIZE: prdata = {23'd0, r_ring_size};
            nccm_pkg::REG_MAX_SCAN:  prdata = {26'd0, r_max_scan};
            nccm_pkg::REG_IRQ_MASK:  prdata = {16'd0, r_irq_mask};
            nccm_pkg::REG_QID_FIRST: prdata = {28'd0, r_qid_first};
            nccm_pkg::REG_QID_LAST:  prdata = {28'd0, r_qid_last};
            nccm_pkg::REG_QID_STEP:  prdata = {28'd0, r_qid_stride};
            default:                 prdata = '0;
        endcase
    end

    nccm_pkg::t_item   in_item, q_item;
    nccm_pkg::t_result res;
    logic q_valid, q_ready;

    assign in_item = '{opcode: i_opcode, time_value: i_time_value,
                       internal_flag: i_internal_flag, cq_index: i_cq_index,
                       sq_index: i_sq_index, cmd_ident: i_cmd_ident,
                       head_value: i_head_value};

    nccm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(in_item), .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item));

    nccm_back #(.RING_DEPTH(RING_DEPTH), .NUM_QUEUES(NUM_QUEUES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_item(q_item), .o_valid(o_valid), .i_ready(i_ready), .o_res(res),
        .i_cq_size(r_cq_size), .i_ring_size(r_ring_size), .i_max_scan(r_max_scan),
        .i_irq_mask(r_irq_mask), .i_qid_first(r_qid_first), .i_qid_last(r_qid_last),
        .i_qid_stride(r_qid_stride));

    assign o_kind        = res.kind;
    assign o_out_cq      = res.out_cq;
    assign o_cq_slot     = res.cq_slot;
    assign o_out_sq_head = res.out_sq_head;
    assign o_out_sq      = res.out_sq;
    assign o_out_cmd     = res.out_cmd;
    assign o_phase_bit   = res.phase_bit;
    assign o_retired     = res.retired;
    assign o_last        = res.last;
endmodule
`default_nettype wire
